// ----- rtl/rked_pkg.sv -----
// Shared types and constants for the remote key event dispatcher.
package rked_pkg;

   localparam int REQ_W = 104;
   localparam int RSP_W = 80;

   localparam logic [2:0] CMD_PRESS        = 3'd0;
   localparam logic [2:0] CMD_REPEAT       = 3'd1;
   localparam logic [2:0] CMD_SET_DIGIT    = 3'd2;
   localparam logic [2:0] CMD_REGISTER     = 3'd3;
   localparam logic [2:0] CMD_SET_INTERVAL = 3'd4;

   localparam logic [2:0] EV_NONE          = 3'd0;
   localparam logic [2:0] EV_DIGIT_PRESS   = 3'd1;
   localparam logic [2:0] EV_DIGIT_HOLD    = 3'd2;
   localparam logic [2:0] EV_KEY_PRESS     = 3'd3;
   localparam logic [2:0] EV_KEY_HOLD      = 3'd4;

   localparam logic [1:0] KIND_NONE        = 2'd0;
   localparam logic [1:0] KIND_DIGIT       = 2'd1;
   localparam logic [1:0] KIND_KEY         = 2'd2;

   localparam logic [31:0] NEW_KEY_INTERVAL = 32'h0001_0000;
   localparam logic [31:0] NUM_HOLD_RESET   = 32'h0001_0000;

   typedef struct packed {
      logic load;
      logic dig_next;
      logic key_scan;
      logic press_dig;
      logic press_key;
      logic reg_found;
      logic reg_new;
      logic rep_do;
      logic out_load;
   } dp_ctl_type;

   typedef struct packed {
      logic [2:0] req_cmd;
      logic [2:0] cmd;
      logic       dig_hit;
      logic       dig_last;
      logic       key_hit;
      logic       key_miss;
      logic       out_free;
   } dp_sts_type;

endpackage

// ----- rtl/remote_key_event_dispatcher_core.sv -----
// Top level of the remote key event dispatcher.
// Takes one item at a time. A press item walks the numeric-key table one entry
// per cycle and, if no numeric key matches, then the registered-key memory one
// entry per cycle through its single read port; register and interval items
// walk the key memory only, while repeat, set-digit and unknown items walk no
// table. The result sits in an output register, and the next item is taken
// once the current result has been loaded there. The hold interval for numeric
// keys is written through the csr port; the user must write it only while the
// block is idle, which the block itself does not enforce.
module remote_key_event_dispatcher_core #(
   parameter int DIGIT_KEYS = 10,
   parameter int KEY_SLOTS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [31:0]                csr_wr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // command[2:0], code[34:3], digit_number[38:35], hold_interval[70:39],
   // time_ms[102:71], zero pad[103]
   input  logic [rked_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // event_res[2:0], digit_out[6:3], slot_out[10:7], code_out[42:11],
   // held_ms[74:43], zero pad[79:75]
   output logic [rked_pkg::RSP_W-1:0] rsp_tdata
);
   import rked_pkg::*;

   dp_ctl_type ctl;
   dp_sts_type sts;

   rked_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   rked_datapath #(
      .DIGIT_KEYS (DIGIT_KEYS),
      .KEY_SLOTS  (KEY_SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .ctl         (ctl),
      .sts         (sts)
   );

endmodule

// ----- rtl/rked_ctrl.sv -----
// Sequencer that walks the code tables and steers the datapath.
module rked_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rked_pkg::dp_sts_type sts,
   output rked_pkg::dp_ctl_type ctl
);
   import rked_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIGIT  = 3'd1;
   localparam logic [2:0] S_KEY    = 3'd2;
   localparam logic [2:0] S_REPEAT = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      ctl        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               unique case (sts.req_cmd)
                  CMD_PRESS:        state_in = S_DIGIT;
                  CMD_REPEAT:       state_in = S_REPEAT;
                  CMD_REGISTER,
                  CMD_SET_INTERVAL: state_in = S_KEY;
                  default:          state_in = S_OUT;
               endcase
            end
         end
         S_DIGIT: begin
            priority if (sts.dig_hit) begin
               ctl.press_dig = 1'b1;
               state_in      = S_OUT;
            end else if (sts.dig_last) begin
               state_in = S_KEY;
            end else begin
               ctl.dig_next = 1'b1;
            end
         end
         S_KEY: begin
            ctl.key_scan = 1'b1;
            priority if (sts.key_hit) begin
               if (sts.cmd == CMD_PRESS) begin
                  ctl.press_key = 1'b1;
               end else begin
                  ctl.reg_found = 1'b1;
               end
               state_in = S_OUT;
            end else if (sts.key_miss) begin
               if (sts.cmd != CMD_PRESS) begin
                  ctl.reg_new = 1'b1;
               end
               state_in = S_OUT;
            end
         end
         S_REPEAT: begin
            ctl.rep_do = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rked_datapath.sv -----
// Code tables, key memories, hold timer and result register.
module rked_datapath #(
   parameter int DIGIT_KEYS = 10,
   parameter int KEY_SLOTS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [31:0]                 csr_wr_data,
   input  logic [rked_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rked_pkg::RSP_W-1:0]  rsp_tdata,
   input  rked_pkg::dp_ctl_type        ctl,
   output rked_pkg::dp_sts_type        sts
);
   import rked_pkg::*;

   localparam int DW   = (DIGIT_KEYS > 1) ? $clog2(DIGIT_KEYS) : 1;
   localparam int KW   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int KC_W = $clog2(KEY_SLOTS + 1);
   localparam int KA_W = $clog2(KEY_SLOTS + 2);
   localparam int LW   = (DW > KW) ? DW : KW;

   logic [2:0]  r_cmd;
   logic [31:0] r_code;
   logic [3:0]  r_dnum;
   logic [31:0] r_hint;
   logic [31:0] r_time;

   logic [2:0]  cmd_ff;
   logic [31:0] code_ff;
   logic [31:0] hint_ff;
   logic [31:0] time_ff;

   logic [31:0] digit_code_ff [DIGIT_KEYS];
   logic [31:0] digit_code_in [DIGIT_KEYS];
   logic [31:0] num_hold_ff, num_hold_in;

   logic [DW-1:0]   dig_idx_ff, dig_idx_in;
   logic [KA_W-1:0] kaddr_ff, kaddr_in;
   logic            rd_pend_ff, rd_pend_in;
   logic [KW-1:0]   rd_idx_ff, rd_idx_in;
   logic [KC_W-1:0] key_count_ff, key_count_in;

   logic [1:0]      last_kind_ff, last_kind_in;
   logic [LW-1:0]   last_index_ff, last_index_in;
   logic [31:0]     press_time_ff, press_time_in;
   logic [31:0]     active_ff, active_in;
   logic [31:0]     next_hold_ff, next_hold_in;

   logic [2:0]      res_event_ff, res_event_in;
   logic [3:0]      res_digit_ff, res_digit_in;
   logic [3:0]      res_slot_ff, res_slot_in;
   logic [31:0]     res_code_ff, res_code_in;
   logic [31:0]     res_held_ff, res_held_in;

   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [31:0]     key_code_mem [KEY_SLOTS];
   logic [31:0]     key_int_mem  [KEY_SLOTS];
   logic [31:0]     rd_code_ff;
   logic [31:0]     rd_int_ff;
   logic [KW-1:0]   rd_addr;

   logic            code_we;
   logic            int_we;
   logic [KW-1:0]   wr_addr;
   logic [31:0]     wr_int;

   logic            dig_hit;
   logic            key_hit;
   logic            key_miss;
   logic [KW-1:0]   new_slot;
   logic            out_free;

   assign r_cmd  = req_tdata[2:0];
   assign r_code = req_tdata[34:3];
   assign r_dnum = req_tdata[38:35];
   assign r_hint = req_tdata[70:39];
   assign r_time = req_tdata[102:71];

   assign dig_hit  = (digit_code_ff[dig_idx_ff] == code_ff);
   assign key_hit  = rd_pend_ff && (rd_code_ff == code_ff);
   assign key_miss = (kaddr_ff != '0) && !rd_pend_ff;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign new_slot = (key_count_ff >= KC_W'(KEY_SLOTS)) ? KW'(KEY_SLOTS - 1)
                                                        : key_count_ff[KW-1:0];
   assign rd_addr  = ctl.key_scan ? kaddr_ff[KW-1:0] : last_index_ff[KW-1:0];

   assign sts.req_cmd  = r_cmd;
   assign sts.cmd      = cmd_ff;
   assign sts.dig_hit  = dig_hit;
   assign sts.dig_last = (dig_idx_ff == DW'(DIGIT_KEYS - 1));
   assign sts.key_hit  = key_hit;
   assign sts.key_miss = key_miss;
   assign sts.out_free = out_free;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      digit_code_in = digit_code_ff;
      num_hold_in   = num_hold_ff;
      dig_idx_in    = dig_idx_ff;
      kaddr_in      = kaddr_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      key_count_in  = key_count_ff;
      last_kind_in  = last_kind_ff;
      last_index_in = last_index_ff;
      press_time_in = press_time_ff;
      active_in     = active_ff;
      next_hold_in  = next_hold_ff;
      res_event_in  = res_event_ff;
      res_digit_in  = res_digit_ff;
      res_slot_in   = res_slot_ff;
      res_code_in   = res_code_ff;
      res_held_in   = res_held_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      code_we       = 1'b0;
      int_we        = 1'b0;
      wr_addr       = new_slot;
      wr_int        = NEW_KEY_INTERVAL;

      if (csr_wr_en) begin
         num_hold_in = csr_wr_data;
      end

      if (ctl.load) begin
         dig_idx_in   = '0;
         kaddr_in     = '0;
         rd_pend_in   = 1'b0;
         res_event_in = EV_NONE;
         res_digit_in = '0;
         res_slot_in  = '0;
         res_code_in  = '0;
         res_held_in  = '0;
         if (r_cmd == CMD_PRESS) begin
            press_time_in = r_time;
            last_kind_in  = KIND_NONE;
            last_index_in = '0;
         end
         if ((r_cmd == CMD_SET_DIGIT) && ({1'b0, r_dnum} < 5'(DIGIT_KEYS))) begin
            digit_code_in[r_dnum[DW-1:0]] = r_code;
         end
      end

      if (ctl.dig_next) begin
         dig_idx_in = dig_idx_ff + 1'b1;
      end

      if (ctl.key_scan) begin
         rd_pend_in = (kaddr_ff < KA_W'(key_count_ff));
         rd_idx_in  = kaddr_ff[KW-1:0];
         kaddr_in   = kaddr_ff + 1'b1;
      end

      if (ctl.press_dig) begin
         last_kind_in  = KIND_DIGIT;
         last_index_in = LW'(dig_idx_ff);
         active_in     = num_hold_ff;
         next_hold_in  = time_ff + num_hold_ff;
         res_event_in  = EV_DIGIT_PRESS;
         res_digit_in  = 4'(dig_idx_ff);
      end

      if (ctl.press_key) begin
         last_kind_in  = KIND_KEY;
         last_index_in = LW'(rd_idx_ff);
         active_in     = rd_int_ff;
         next_hold_in  = time_ff + rd_int_ff;
         res_event_in  = EV_KEY_PRESS;
         res_slot_in   = 4'(rd_idx_ff);
         res_code_in   = code_ff;
      end

      if (ctl.reg_found) begin
         wr_addr = rd_idx_ff;
         wr_int  = hint_ff;
         int_we  = (cmd_ff == CMD_SET_INTERVAL);
      end

      if (ctl.reg_new) begin
         wr_addr      = new_slot;
         wr_int       = (cmd_ff == CMD_SET_INTERVAL) ? hint_ff : NEW_KEY_INTERVAL;
         code_we      = 1'b1;
         int_we       = 1'b1;
         key_count_in = KC_W'(new_slot) + 1'b1;
      end

      if (ctl.rep_do && (time_ff >= next_hold_ff) && (last_kind_ff != KIND_NONE)) begin
         res_held_in  = time_ff - press_time_ff;
         next_hold_in = time_ff + active_ff;
         if (last_kind_ff == KIND_DIGIT) begin
            res_event_in = EV_DIGIT_HOLD;
            res_digit_in = 4'(last_index_ff);
         end else begin
            res_event_in = EV_KEY_HOLD;
            res_slot_in  = 4'(last_index_ff);
            res_code_in  = rd_code_ff;
         end
      end

      if (ctl.out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {5'd0, res_held_ff, res_code_ff, res_slot_ff,
                          res_digit_ff, res_event_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_KEYS; i++) begin
            digit_code_ff[i] <= '0;
         end
         num_hold_ff   <= NUM_HOLD_RESET;
         dig_idx_ff    <= '0;
         kaddr_ff      <= '0;
         rd_pend_ff    <= 1'b0;
         key_count_ff  <= '0;
         last_kind_ff  <= KIND_NONE;
         last_index_ff <= '0;
         press_time_ff <= '0;
         active_ff     <= '0;
         next_hold_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         digit_code_ff <= digit_code_in;
         num_hold_ff   <= num_hold_in;
         dig_idx_ff    <= dig_idx_in;
         kaddr_ff      <= kaddr_in;
         rd_pend_ff    <= rd_pend_in;
         key_count_ff  <= key_count_in;
         last_kind_ff  <= last_kind_in;
         last_index_ff <= last_index_in;
         press_time_ff <= press_time_in;
         active_ff     <= active_in;
         next_hold_ff  <= next_hold_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= r_cmd;
         code_ff <= r_code;
         hint_ff <= r_hint;
         time_ff <= r_time;
      end
      rd_idx_ff    <= rd_idx_in;
      res_event_ff <= res_event_in;
      res_digit_ff <= res_digit_in;
      res_slot_ff  <= res_slot_in;
      res_code_ff  <= res_code_in;
      res_held_ff  <= res_held_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (code_we) begin
         key_code_mem[wr_addr] <= code_ff;
      end
      if (int_we) begin
         key_int_mem[wr_addr] <= wr_int;
      end
      rd_code_ff <= key_code_mem[rd_addr];
      rd_int_ff  <= key_int_mem[rd_addr];
   end

   a_key_count_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KC_W'(KEY_SLOTS))
      else $error("key count beyond table size");

   a_hit_miss_excl: assert property (@(posedge clock) disable iff (reset)
      !(key_hit && key_miss))
      else $error("key scan reports hit and miss together");

   a_digit_arm: assert property (@(posedge clock) disable iff (reset)
      ctl.press_dig |=> (last_kind_ff == KIND_DIGIT) &&
                        (next_hold_ff == press_time_ff + active_ff))
      else $error("digit press did not arm the hold timer");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |=> rsp_tvalid_ff)
      else $error("loaded result not presented");

endmodule
